// File: design/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants of the pulse packet deframer.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int PULSE_W    = 16;
  localparam int BYTE_W     = 8;
  localparam int STAT_W     = 3;
  localparam int KEPT_W     = 6;
  localparam int TOTAL_W    = 32;
  localparam int SIZE_BYTES = 4;

  localparam logic [BYTE_W-1:0] HEADER_MARK = 8'hFF;

  // packet status codes
  localparam logic [STAT_W-1:0] STAT_DATA    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_HDR_NEW = 3'd1;
  localparam logic [STAT_W-1:0] STAT_HDR_REP = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FAIL    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_IDLE    = 3'd4;

  typedef struct packed {
    logic signed [PULSE_W-1:0] pulse;
    logic                      first;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_status;
    logic [STAT_W-1:0] status;
    logic [KEPT_W-1:0] kept_count;
    logic              last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic rx_en;
    logic start;
    logic ck_step;
    logic hd_step;
    logic fin_on;
    logic fin_sub;
    logic fin_kept;
    logic em_load;
    logic st_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pkt_end;
    logic done;
    logic on;
    logic tot_zero;
    logic chunk_end;
    logic chunk_ff;
    logic chunk_nz;
    logic chunk_last;
    logic hd_last;
    logic em_end;
    logic out_free;
  } sts_t;

endpackage

// File: design/ppd_ram.sv
// ----------------------------------------------------------------------------
// ppd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/ppd_ctrl.sv
// ----------------------------------------------------------------------------
// ppd_ctrl
// Sequencer: receive, checksum pass, header capture, final sizing, emit.
// ----------------------------------------------------------------------------
module ppd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  ppd_pkg::sts_t sts,
  output ppd_pkg::cmd_t cmd,
  output logic          in_stall
);

  localparam logic [3:0] S_RECV  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_CK_RD = 4'd2;
  localparam logic [3:0] S_CK_AC = 4'd3;
  localparam logic [3:0] S_HD_RD = 4'd4;
  localparam logic [3:0] S_HD_AC = 4'd5;
  localparam logic [3:0] S_FIN1  = 4'd6;
  localparam logic [3:0] S_FIN2  = 4'd7;
  localparam logic [3:0] S_FIN3  = 4'd8;
  localparam logic [3:0] S_EM_RD = 4'd9;
  localparam logic [3:0] S_EM_WR = 4'd10;
  localparam logic [3:0] S_STAT  = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RECV:  if (sts.pkt_end) state_nxt = S_START;
      S_START: state_nxt = sts.done ? S_STAT : S_CK_RD;
      S_CK_RD: state_nxt = S_CK_AC;
      S_CK_AC: begin
        priority if (!sts.chunk_end) state_nxt = S_CK_RD;
        else if (sts.chunk_ff)       state_nxt = sts.tot_zero ? S_HD_RD : S_STAT;
        else if (sts.chunk_nz)       state_nxt = S_STAT;
        else if (sts.chunk_last)     state_nxt = S_FIN1;
        else                         state_nxt = S_CK_RD;
      end
      S_HD_RD: state_nxt = S_HD_AC;
      S_HD_AC: state_nxt = sts.hd_last ? S_STAT : S_HD_RD;
      S_FIN1:  state_nxt = S_FIN2;
      S_FIN2:  state_nxt = sts.on ? S_FIN3 : S_STAT;
      S_FIN3:  state_nxt = S_EM_RD;
      S_EM_RD: state_nxt = sts.em_end ? S_STAT : S_EM_WR;
      S_EM_WR: if (sts.out_free) state_nxt = S_EM_RD;
      S_STAT:  if (sts.out_free) state_nxt = S_RECV;
      default: state_nxt = S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.rx_en    = (state_r == S_RECV);
    cmd.start    = (state_r == S_START);
    cmd.ck_step  = (state_r == S_CK_AC);
    cmd.hd_step  = (state_r == S_HD_AC);
    cmd.fin_on   = (state_r == S_FIN1);
    cmd.fin_sub  = (state_r == S_FIN2);
    cmd.fin_kept = (state_r == S_FIN3);
    cmd.em_load  = (state_r == S_EM_WR) && sts.out_free;
    cmd.st_load  = (state_r == S_STAT) && sts.out_free;
  end

  assign in_stall = (state_r != S_RECV);

endmodule

// File: design/ppd_dpath.sv
// ----------------------------------------------------------------------------
// ppd_dpath
// Bit slicer and byte packer, data RAM, chunk checksum, file size
// bookkeeping and the output register.
// ----------------------------------------------------------------------------
module ppd_dpath #(
  parameter int PREAMBLE_BYTES = 2,
  parameter int DATA_BYTES     = 32,
  parameter int CHECK_BYTES    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ppd_pkg::cmd_t cmd,
  output ppd_pkg::sts_t sts,
  input  logic          in_valid,
  input  ppd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ppd_pkg::out_t out_data
);

  localparam int KW          = ppd_pkg::KEPT_W;
  localparam int TW          = ppd_pkg::TOTAL_W;
  localparam int BYW         = ppd_pkg::BYTE_W;
  localparam int PACKET_BITS = (PREAMBLE_BYTES + DATA_BYTES + CHECK_BYTES) * 8;
  localparam int PW          = $clog2(PACKET_BITS + 1);
  localparam int BW          = PW - 3;
  localparam int AW          = $clog2(DATA_BYTES);
  localparam int CW          = (CHECK_BYTES > 1) ? $clog2(CHECK_BYTES) : 1;
  localparam int CS          = DATA_BYTES / CHECK_BYTES;

  // receive state
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [BYW-1:0] shift_r, shift_nxt;
  logic [BYW-1:0] parity_r [CHECK_BYTES];
  // judge state
  logic [TW-1:0]  total_r, total_nxt;
  logic [TW-1:0]  recv_r, recv_nxt;
  logic           on_r, on_nxt;
  logic           done_r, done_nxt;
  logic [KW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  chk_r, chk_nxt;
  logic [BYW-1:0] acc_r, acc_nxt;
  logic [ppd_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [KW-1:0]  kept_r, kept_nxt;
  logic [TW-1:0]  over_r, over_nxt;
  logic           ge_r, ge_nxt;
  // output register
  ppd_pkg::out_t  out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [KW-1:0]  hi_tab [CHECK_BYTES];

  logic           rx_take;
  logic           bit_val;
  logic [PW-1:0]  pos_eff;
  logic [PW-1:0]  pos_inc;
  logic [BYW-1:0] shift_new;
  logic [BW-1:0]  byte_idx;
  logic [BW-1:0]  d_idx;
  logic [BW-1:0]  p_idx;
  logic           byte_done;
  logic           ram_we;
  logic           par_we;
  logic [BYW-1:0] rd_data;
  logic [BYW-1:0] acc_fin;
  logic [CW-1:0]  chk_inc;
  logic [TW:0]    diff;
  logic           out_free;

  genvar g;
  for (g = 0; g < CHECK_BYTES; g++) begin : g_hi
    assign hi_tab[g] = KW'((g + 1) * DATA_BYTES / CHECK_BYTES);
  end

  // receive path: slice, pack LSB first, route each finished byte
  assign rx_take   = cmd.rx_en && in_valid && (in_data.first || (pos_r != '0));
  assign bit_val   = !in_data.pulse[ppd_pkg::PULSE_W-1] && (in_data.pulse != '0);
  assign pos_eff   = in_data.first ? '0 : pos_r;
  assign pos_inc   = pos_eff + 1'b1;
  assign shift_new = {bit_val, (in_data.first ? 7'd0 : shift_r[BYW-1:1])};
  assign byte_idx  = pos_eff[PW-1:3];
  assign d_idx     = byte_idx - BW'(PREAMBLE_BYTES);
  assign p_idx     = d_idx - BW'(DATA_BYTES);
  assign byte_done = rx_take && (pos_eff[2:0] == 3'd7)
                     && (byte_idx >= BW'(PREAMBLE_BYTES));
  assign ram_we    = byte_done && (d_idx < BW'(DATA_BYTES));
  assign par_we    = byte_done && !(d_idx < BW'(DATA_BYTES))
                     && (p_idx < BW'(CHECK_BYTES));

  ppd_ram #(
    .WIDTH (BYW),
    .DEPTH (DATA_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (d_idx[AW-1:0]),
    .wr_data (shift_new),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign acc_fin  = acc_r ^ rd_data;
  assign chk_inc  = (chk_r == CW'(CHECK_BYTES - 1)) ? '0 : chk_r + 1'b1;
  assign diff     = {1'b0, recv_r} - {1'b0, total_r};
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    pos_nxt       = pos_r;
    shift_nxt     = shift_r;
    total_nxt     = total_r;
    recv_nxt      = recv_r;
    on_nxt        = on_r;
    done_nxt      = done_r;
    cnt_nxt       = cnt_r;
    chk_nxt       = chk_r;
    acc_nxt       = acc_r;
    stat_nxt      = stat_r;
    kept_nxt      = kept_r;
    over_nxt      = over_r;
    ge_nxt        = ge_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (rx_take) begin
      shift_nxt = shift_new;
      pos_nxt   = (pos_inc == PW'(PACKET_BITS)) ? '0 : pos_inc;
    end

    if (cmd.start) begin
      kept_nxt = '0;
      cnt_nxt  = hi_tab[0] - KW'(CS);
      chk_nxt  = '0;
      acc_nxt  = parity_r[0];
      if (done_r) begin
        stat_nxt = ppd_pkg::STAT_IDLE;
      end else if (on_r) begin
        recv_nxt = recv_r + TW'(DATA_BYTES);
      end
    end

    if (cmd.ck_step) begin
      if (cnt_r != hi_tab[chk_r] - 1'b1) begin
        acc_nxt = acc_fin;
        cnt_nxt = cnt_r + 1'b1;
      end else if (acc_fin == ppd_pkg::HEADER_MARK) begin
        stat_nxt = (total_r == '0) ? ppd_pkg::STAT_HDR_NEW : ppd_pkg::STAT_HDR_REP;
        cnt_nxt  = '0;
      end else if (acc_fin != '0) begin
        stat_nxt = ppd_pkg::STAT_FAIL;
      end else begin
        // next chunk; unused after the last one
        chk_nxt = chk_inc;
        cnt_nxt = hi_tab[chk_inc] - KW'(CS);
        acc_nxt = parity_r[chk_inc];
      end
    end

    if (cmd.hd_step) begin
      // shift in little endian: byte 0 lands in the low bits
      total_nxt = {rd_data, total_r[TW-1:BYW]};
      cnt_nxt   = cnt_r + 1'b1;
    end

    if (cmd.fin_on && !on_r && (total_r != '0)) begin
      on_nxt   = 1'b1;
      recv_nxt = TW'(DATA_BYTES);
    end

    if (cmd.fin_sub) begin
      over_nxt = diff[TW-1:0];
      ge_nxt   = !diff[TW];
      stat_nxt = on_r ? ppd_pkg::STAT_DATA : ppd_pkg::STAT_IDLE;
    end

    if (cmd.fin_kept) begin
      cnt_nxt = '0;
      if (ge_r) begin
        done_nxt = 1'b1;
        kept_nxt = (over_r >= TW'(DATA_BYTES)) ? '0
                   : KW'(DATA_BYTES) - over_r[KW-1:0];
      end else begin
        kept_nxt = KW'(DATA_BYTES);
      end
    end

    if (cmd.em_load) begin
      out_nxt.out_byte   = rd_data;
      out_nxt.is_status  = 1'b0;
      out_nxt.status     = ppd_pkg::STAT_DATA;
      out_nxt.kept_count = kept_r;
      out_nxt.last       = 1'b0;
      out_valid_nxt      = 1'b1;
      cnt_nxt            = cnt_r + 1'b1;
    end

    if (cmd.st_load) begin
      out_nxt.out_byte   = '0;
      out_nxt.is_status  = 1'b1;
      out_nxt.status     = stat_r;
      out_nxt.kept_count = kept_r;
      out_nxt.last       = 1'b1;
      out_valid_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      shift_r     <= '0;
      total_r     <= '0;
      recv_r      <= '0;
      on_r        <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      shift_r     <= shift_nxt;
      total_r     <= total_nxt;
      recv_r      <= recv_nxt;
      on_r        <= on_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    chk_r  <= chk_nxt;
    acc_r  <= acc_nxt;
    stat_r <= stat_nxt;
    kept_r <= kept_nxt;
    over_r <= over_nxt;
    ge_r   <= ge_nxt;
    out_r  <= out_nxt;
    if (par_we) begin
      parity_r[p_idx[CW-1:0]] <= shift_new;
    end
  end

  always_comb begin
    sts            = '0;
    sts.pkt_end    = rx_take && (pos_inc == PW'(PACKET_BITS));
    sts.done       = done_r;
    sts.on         = on_r;
    sts.tot_zero   = (total_r == '0);
    sts.chunk_end  = (cnt_r == hi_tab[chk_r] - 1'b1);
    sts.chunk_ff   = (acc_fin == ppd_pkg::HEADER_MARK);
    sts.chunk_nz   = (acc_fin != '0);
    sts.chunk_last = (chk_r == CW'(CHECK_BYTES - 1));
    sts.hd_last    = (cnt_r == KW'(ppd_pkg::SIZE_BYTES - 1));
    sts.em_end     = (cnt_r == kept_r);
    sts.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("end of file flag cleared");

  a_done_needs_on: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> on_r)
    else $error("stream ended without having started");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.em_load || cmd.st_load) |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while held");

  a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_status |-> out_r.last && (out_r.out_byte == '0))
    else $error("malformed status item");

  a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.em_load |-> (cnt_r < kept_r) && (kept_r <= KW'(DATA_BYTES)))
    else $error("data byte emitted beyond kept count");

endmodule

// File: design/pulse_packet_deframer.sv
// ----------------------------------------------------------------------------
// pulse_packet_deframer
// Slices aligned pulse samples to bits, packs bytes, checks chunk checksums,
// tracks the file size from the header and emits kept bytes plus a status.
// ----------------------------------------------------------------------------
//   channel | ports                        | payload
//   input   | in_valid, in_stall, in_data  | ppd_pkg::in_t  (pulse, first)
//   output  | out_valid, out_stall, out_data| ppd_pkg::out_t (byte, status..)
//
// One cycle per pulse while a packet is received.
// At packet end the input stalls for the judge pass: a start step, a checksum
// pass over each checked data byte through the data RAM read port, a header
// capture, sizing, then each kept byte, a check for the end of the bytes and
// the status item; an ended stream goes from the start step to the status.
// Output stall holds the output register and extends the emit phase.
// Synchronous reset; no clearing pass, the data RAM is always filled first.
// ----------------------------------------------------------------------------
module pulse_packet_deframer #(
  parameter int PREAMBLE_BYTES = 2,
  parameter int DATA_BYTES     = 32,
  parameter int CHECK_BYTES    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ppd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ppd_pkg::out_t out_data
);

  ppd_pkg::cmd_t cmd;
  ppd_pkg::sts_t sts;

  ppd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  ppd_dpath #(
    .PREAMBLE_BYTES (PREAMBLE_BYTES),
    .DATA_BYTES     (DATA_BYTES),
    .CHECK_BYTES    (CHECK_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
